/* rtl/hsvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared constants, sector codes and stage payload types of the HSV to RGB
// converter pipeline.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  localparam int unsigned NumStages = 5;

  localparam logic [7:0]  FullScale   = 8'd255;
  localparam logic [15:0] FullScaleSq = 16'd65025;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  // Rounding offsets: half up on an odd divisor is floor((x + (d-1)/2) / d)
  localparam logic [6:0]  HalfScale   = 7'd127;
  localparam logic [14:0] HalfScaleSq = 15'd32512;

  // Reciprocals for division by a constant, rounded up; the shifts are wide
  // enough that the quotient is exact over the whole operand range.
  localparam int unsigned PShift = 32;
  localparam int unsigned QShift = 40;
  localparam logic [24:0] RecipP =
    25'(((64'd1 << PShift) + 64'd254) / 64'd255);
  localparam logic [24:0] RecipQ =
    25'(((64'd1 << QShift) + 64'd65024) / 64'd65025);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // after hue split
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  rem;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] p_num;
  } s1_t;

  // after s*rem terms
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  val;
    logic [15:0] q_fac;
    logic [15:0] t_fac;
    logic [7:0]  p;
  } s2_t;

  // after v*factor products
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  val;
    logic [23:0] q_num;
    logic [23:0] t_num;
    logic [7:0]  p;
  } s3_t;

  // all channel terms ready
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  val;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  p;
  } s4_t;

endpackage

/* rtl/hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// 8-bit HSV to packed ARGB conversion, five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one hue/saturation/value request per clock while in_stall_o is low
// and returns the packed colour {8'hFF, red, green, blue}, sustaining one
// item per cycle while out_stall_i is low. Hue split, the s*rem products,
// the v*factor products, the reciprocal rounding multiply and the output
// register each hold one stage. Zero saturation falls out of the same
// arithmetic as grey. A stall on the output freezes only the stages
// that are full, so bubbles are squeezed out and the input keeps taking
// requests until the pipeline is full.
module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packed_color_o
);
  import hsvc_pkg::*;

  logic [NumStages-1:0] adv;
  s1_t                  s1;
  s4_t                  s4;

  hsvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .adv_o       (adv)
  );

  hsvc_sector u_sector (
    .clk_i        (clk_i),
    .en_i         (adv[0]),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .value_i      (value_i),
    .s1_o         (s1)
  );

  hsvc_round u_round (
    .clk_i (clk_i),
    .en_i  (adv[3:1]),
    .s1_i  (s1),
    .s4_o  (s4)
  );

  hsvc_place u_place (
    .clk_i          (clk_i),
    .en_i           (adv[4]),
    .s4_i           (s4),
    .packed_color_o (packed_color_o)
  );

endmodule

/* rtl/hsvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_ctrl
// Valid bits and per-stage advance enables of the pipeline.
// ----------------------------------------------------------------------------
module hsvc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hsvc_pkg::NumStages-1:0] adv_o
);
  import hsvc_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] adv;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv_o       = adv;
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NumStages-1];

endmodule

/* rtl/hsvc_sector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_sector
// First stage: hue wrap, split of 6*hue by 255 into sector and remainder,
// and the v*(255-s) product for p.
// ----------------------------------------------------------------------------
module hsvc_sector (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        value_i,
  output hsvc_pkg::s1_t     s1_o
);
  import hsvc_pkg::*;

  logic [7:0]  hue_w;
  logic [10:0] scaled;
  logic [10:0] base;
  sector_e     sector;
  logic [7:0]  sat_inv;
  s1_t         s1_d, s1_q;

  assign hue_w  = (hue_i == FullScale) ? 8'd0 : hue_i;
  assign scaled = 11'(hue_w) * 11'd6;

  always_comb begin
    if (scaled >= 11'd1275) begin
      sector = SEC_MAG_RED;
      base   = 11'd1275;
    end else if (scaled >= 11'd1020) begin
      sector = SEC_BLU_MAG;
      base   = 11'd1020;
    end else if (scaled >= 11'd765) begin
      sector = SEC_CYN_BLU;
      base   = 11'd765;
    end else if (scaled >= 11'd510) begin
      sector = SEC_GRN_CYN;
      base   = 11'd510;
    end else if (scaled >= 11'd255) begin
      sector = SEC_YEL_GRN;
      base   = 11'd255;
    end else begin
      sector = SEC_RED_YEL;
      base   = 11'd0;
    end
  end

  assign sat_inv = FullScale - saturation_i;

  always_comb begin
    s1_d.sector = sector;
    s1_d.rem    = 8'(scaled - base);
    s1_d.sat    = saturation_i;
    s1_d.val    = value_i;
    s1_d.p_num  = {8'd0, value_i} * {8'd0, sat_inv};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

/* rtl/hsvc_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_round
// Stages two to four: p, q and t terms, each a product rounded half up
// through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvc_round (
  input  logic              clk_i,
  input  logic [2:0]        en_i,
  input  hsvc_pkg::s1_t     s1_i,
  output hsvc_pkg::s4_t     s4_o
);
  import hsvc_pkg::*;

  // stage 2
  logic [7:0]  rem_inv;
  logic [15:0] s_rem, s_rem_inv;
  logic [16:0] p_off;
  logic [41:0] p_prod;
  s2_t         s2_d, s2_q;
  // stage 3
  s3_t         s3_d, s3_q;
  // stage 4
  logic [48:0] q_prod, t_prod;
  s4_t         s4_d, s4_q;

  assign rem_inv   = FullScale - s1_i.rem;
  assign s_rem     = {8'd0, s1_i.sat} * {8'd0, s1_i.rem};
  assign s_rem_inv = {8'd0, s1_i.sat} * {8'd0, rem_inv};
  assign p_off     = {1'b0, s1_i.p_num} + 17'(HalfScale);
  assign p_prod    = 42'(p_off) * 42'(RecipP);

  always_comb begin
    s2_d.sector = s1_i.sector;
    s2_d.val    = s1_i.val;
    s2_d.q_fac  = FullScaleSq - s_rem;
    s2_d.t_fac  = FullScaleSq - s_rem_inv;
    s2_d.p      = p_prod[PShift +: 8];
  end

  always_comb begin
    s3_d.sector = s2_q.sector;
    s3_d.val    = s2_q.val;
    s3_d.q_num  = 24'(s2_q.val) * 24'(s2_q.q_fac) + 24'(HalfScaleSq);
    s3_d.t_num  = 24'(s2_q.val) * 24'(s2_q.t_fac) + 24'(HalfScaleSq);
    s3_d.p      = s2_q.p;
  end

  assign q_prod = 49'(s3_q.q_num) * 49'(RecipQ);
  assign t_prod = 49'(s3_q.t_num) * 49'(RecipQ);

  always_comb begin
    s4_d.sector = s3_q.sector;
    s4_d.val    = s3_q.val;
    s4_d.q      = q_prod[QShift +: 8];
    s4_d.t      = t_prod[QShift +: 8];
    s4_d.p      = s3_q.p;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s2_q <= s2_d;
    end
    if (en_i[1]) begin
      s3_q <= s3_d;
    end
    if (en_i[2]) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

/* rtl/hsvc_place.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_place
// Last stage: places v, p, q and t on red, green and blue by sector and
// registers the packed opaque colour word.
// ----------------------------------------------------------------------------
module hsvc_place (
  input  logic              clk_i,
  input  logic              en_i,
  input  hsvc_pkg::s4_t     s4_i,
  output logic [31:0]       packed_color_o
);
  import hsvc_pkg::*;

  logic [7:0]  red, green, blue;
  logic [31:0] color_q;

  always_comb begin
    case (s4_i.sector)
      SEC_RED_YEL: begin
        red = s4_i.val; green = s4_i.t;   blue = s4_i.p;
      end
      SEC_YEL_GRN: begin
        red = s4_i.q;   green = s4_i.val; blue = s4_i.p;
      end
      SEC_GRN_CYN: begin
        red = s4_i.p;   green = s4_i.val; blue = s4_i.t;
      end
      SEC_CYN_BLU: begin
        red = s4_i.p;   green = s4_i.q;   blue = s4_i.val;
      end
      SEC_BLU_MAG: begin
        red = s4_i.t;   green = s4_i.p;   blue = s4_i.val;
      end
      default: begin
        red = s4_i.val; green = s4_i.p;   blue = s4_i.q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      color_q <= {AlphaOpaque, red, green, blue};
    end
  end

  assign packed_color_o = color_q;

endmodule
